@@ rtl/multi_keyword_byte_matcher_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the multi-keyword byte matcher
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// -----------------------------------------------------------------------------
`ifndef MULTI_KEYWORD_BYTE_MATCHER_MACROS_SVH
`define MULTI_KEYWORD_BYTE_MATCHER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define MKBM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mkbm assertion failed");
// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define MKBM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mkbm assertion failed");
`else
`define MKBM_ASSERT_IMP(lbl, ante, cons)
`define MKBM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/mkbm_pkg.sv @@
// -----------------------------------------------------------------------------
// Multi-keyword byte matcher package
// Sizes, item mode codes and the records passed between front and back.
// -----------------------------------------------------------------------------
package mkbm_pkg;

    localparam int NUM_KEYWORDS = 16;
    localparam int MAX_LEN      = 32;

    // Fixed field widths of the item and result transfers.
    localparam int MODE_W = 2;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int OFS_W  = 32;

    localparam int SEEN_W    = $clog2(MAX_LEN + 1);
    localparam int KPOS_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int KEY_IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int PB_DEPTH  = NUM_KEYWORDS * MAX_LEN;
    localparam int PB_ADDR_W = (PB_DEPTH > 1) ? $clog2(PB_DEPTH) : 1;

    // The queue pointers wrap naturally, so the depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_KEY_BYTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY_LEN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART  = 2'd3;

    localparam logic [OFS_W-1:0] OFFSET_MAX = '1;

    // One scanned byte that hit at least one keyword.
    typedef struct packed {
        logic [NUM_KEYWORDS-1:0]            mask;
        logic [OFS_W-1:0]                   here;
        logic [NUM_KEYWORDS-1:0][LEN_W-1:0] lens;
    } t_scan_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/mkbm_if.sv @@
// -----------------------------------------------------------------------------
// Multi-keyword byte matcher channels
// Valid/ready interfaces for the item input and the match result output.
// -----------------------------------------------------------------------------
interface mkbm_item_if
    import mkbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  char_pos;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  pattern_length;

    modport source (output valid, mode, slot, char_pos, byte_value, pattern_length,
                    input ready);
    modport sink   (input valid, mode, slot, char_pos, byte_value, pattern_length,
                    output ready);
endinterface

interface mkbm_match_if
    import mkbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] match_slot;
    logic [OFS_W-1:0]  match_offset;
    logic              last_match;

    modport source (output valid, match_slot, match_offset, last_match, input ready);
    modport sink   (input valid, match_slot, match_offset, last_match, output ready);
endinterface

@@ rtl/mkbm_ram.sv @@
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module mkbm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/mkbm_front.sv @@
// -----------------------------------------------------------------------------
// Matcher front end
// Accepts items, keeps the keyword table and history, compares every slot.
// -----------------------------------------------------------------------------
module mkbm_front
    import mkbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    mkbm_item_if.sink        i_item,
    input  t_q_status        i_q_status,
    output logic             o_push,
    output t_scan_res        o_push_data,
    output logic             o_sweep_busy
);

    // Keyword bytes stored right-aligned: entry k holds the byte that must
    // sit k places back in the history for the keyword to end here.
    logic [BYTE_W-1:0]    r_aln [NUM_KEYWORDS][MAX_LEN];
    logic [LEN_W-1:0]     r_len [NUM_KEYWORDS];
    logic [BYTE_W-1:0]    r_hist [MAX_LEN];
    logic [SEEN_W-1:0]    r_seen;
    logic [OFS_W-1:0]     r_offset;
    logic                 r_s1_vld;
    logic [OFS_W-1:0]     r_s1_here;
    logic                 r_sw_act;
    logic [SEEN_W-1:0]    r_sw_cnt;
    logic [KEY_IDX_W-1:0] r_sw_slot;
    logic [LEN_W-1:0]     r_sw_len;
    logic                 r_rd_vld;
    logic [KPOS_W-1:0]    r_rd_pos;

    logic                 accept;
    logic                 do_key_byte;
    logic                 do_key_len;
    logic                 do_scan;
    logic                 do_restart;
    logic                 slot_ok;
    logic                 pos_ok;
    logic [KEY_IDX_W-1:0] slot_idx;
    logic [LEN_W-1:0]     len_sat;
    logic [LEN_W-1:0]     cur_len;
    logic [LEN_W-1:0]     key_rev;
    logic [LEN_W-1:0]     sw_rev;
    logic [BYTE_W-1:0]    ram_rd_data;
    logic [PB_ADDR_W-1:0] ram_wr_addr;
    logic [PB_ADDR_W-1:0] ram_rd_addr;
    logic [NUM_KEYWORDS-1:0] hit_mask;

    assign o_sweep_busy  = r_sw_act || r_rd_vld;
    assign i_item.ready  = !o_sweep_busy && (!r_s1_vld || !i_q_status.full);
    assign accept        = i_item.valid && i_item.ready;

    assign slot_ok  = int'(i_item.slot) < NUM_KEYWORDS;
    assign pos_ok   = int'(i_item.char_pos) < MAX_LEN;
    assign slot_idx = i_item.slot[KEY_IDX_W-1:0];
    assign len_sat  = (int'(i_item.pattern_length) > MAX_LEN) ? LEN_W'(MAX_LEN)
                                                             : i_item.pattern_length;
    assign cur_len  = r_len[slot_idx];
    assign key_rev  = cur_len - LEN_W'(1) - LEN_W'(i_item.char_pos);
    assign sw_rev   = r_sw_len - LEN_W'(1) - LEN_W'(r_rd_pos);

    always_comb begin
        do_key_byte = 1'b0;
        do_key_len  = 1'b0;
        do_scan     = 1'b0;
        do_restart  = 1'b0;
        if (accept) begin
            case (i_item.mode)
                MODE_KEY_BYTE: do_key_byte = slot_ok && pos_ok;
                MODE_KEY_LEN:  do_key_len  = slot_ok;
                MODE_SCAN:     do_scan     = 1'b1;
                MODE_RESTART:  do_restart  = 1'b1;
                default:       do_scan     = 1'b0;
            endcase
        end
    end

    // Raw keyword bytes; read back only while a slot is realigned.
    assign ram_wr_addr = PB_ADDR_W'(int'(slot_idx) * MAX_LEN + int'(i_item.char_pos));
    assign ram_rd_addr = PB_ADDR_W'(int'(r_sw_slot) * MAX_LEN + int'(r_sw_cnt));

    mkbm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PB_DEPTH)
    ) u_pat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_key_byte),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_item.byte_value),
        .i_rd_en   (r_sw_act),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_KEYWORDS; s++) begin
                r_len[s] <= '0;
            end
            r_seen   <= '0;
            r_offset <= '0;
            r_s1_vld <= 1'b0;
            r_sw_act <= 1'b0;
            r_sw_cnt <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_sw_act;
            if (r_sw_act) begin
                r_sw_cnt <= r_sw_cnt + 1'b1;
                if (r_sw_cnt == SEEN_W'(MAX_LEN - 1)) begin
                    r_sw_act <= 1'b0;
                end
            end
            if (do_key_len) begin
                r_len[slot_idx] <= len_sat;
                r_sw_act        <= 1'b1;
                r_sw_cnt        <= '0;
            end
            if (do_restart) begin
                r_seen   <= '0;
                r_offset <= '0;
            end
            if (do_scan) begin
                if (int'(r_seen) < MAX_LEN) begin
                    r_seen <= r_seen + 1'b1;
                end
                if (r_offset != OFFSET_MAX) begin
                    r_offset <= r_offset + 1'b1;
                end
            end
            r_s1_vld <= do_scan || (r_s1_vld && i_q_status.full);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos <= r_sw_cnt[KPOS_W-1:0];
        if (do_key_len) begin
            r_sw_slot <= slot_idx;
            r_sw_len  <= len_sat;
        end
        if (do_key_byte && (LEN_W'(i_item.char_pos) < cur_len)) begin
            r_aln[slot_idx][key_rev[KPOS_W-1:0]] <= i_item.byte_value;
        end
        if (r_rd_vld && (LEN_W'(r_rd_pos) < r_sw_len)) begin
            r_aln[r_sw_slot][sw_rev[KPOS_W-1:0]] <= ram_rd_data;
        end
        if (do_scan) begin
            r_hist[0] <= i_item.byte_value;
            for (int k = 1; k < MAX_LEN; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_s1_here <= r_offset;
        end
    end

    // Every slot against the history at once, positions past its length masked.
    always_comb begin
        hit_mask = '0;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            hit_mask[s] = (r_len[s] != '0) && (int'(r_seen) >= int'(r_len[s]));
            for (int k = 0; k < MAX_LEN; k++) begin
                if ((k < int'(r_len[s])) && (r_aln[s][k] != r_hist[k])) begin
                    hit_mask[s] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_push_data.mask = hit_mask;
        o_push_data.here = r_s1_here;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            o_push_data.lens[s] = r_len[s];
        end
    end

    assign o_push = r_s1_vld && !i_q_status.full && (hit_mask != '0);

endmodule

@@ rtl/mkbm_queue.sv @@
// -----------------------------------------------------------------------------
// Matcher hit queue
// Small circular buffer of hit records between the front and back ends.
// -----------------------------------------------------------------------------
module mkbm_queue
    import mkbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_scan_res i_push_data,
    input  logic      i_pop,
    output t_scan_res o_head,
    output t_q_status o_status
);

    t_scan_res         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/mkbm_back.sv @@
// -----------------------------------------------------------------------------
// Matcher back end
// Walks the queue head's hit slots in ascending order, one per unstalled cycle.
// -----------------------------------------------------------------------------
module mkbm_back
    import mkbm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_scan_res    i_head,
    input  t_q_status    i_q_status,
    output logic         o_pop,
    mkbm_match_if.source o_match
);

    logic                    r_out_vld;
    logic [SLOT_W-1:0]       r_out_slot;
    logic [OFS_W-1:0]        r_out_offset;
    logic                    r_out_last;
    logic [NUM_KEYWORDS-1:0] r_done;

    logic [NUM_KEYWORDS-1:0] rem;
    logic [NUM_KEYWORDS-1:0] rest;
    logic [KEY_IDX_W-1:0]    sel;
    logic                    found;
    logic                    emit;
    logic [OFS_W-1:0]        start_ofs;

    assign rem = i_head.mask & ~r_done;

    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            if (!found && rem[s]) begin
                sel   = KEY_IDX_W'(s);
                found = 1'b1;
            end
        end
        rest      = rem;
        rest[sel] = 1'b0;
    end

    assign start_ofs = i_head.here - (OFS_W'(i_head.lens[sel]) - OFS_W'(1));
    assign emit      = !i_q_status.empty && (!r_out_vld || o_match.ready);
    assign o_pop     = emit && (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_done    <= '0;
        end else begin
            if (emit) begin
                r_out_vld <= 1'b1;
                r_done    <= (rest == '0) ? '0 : (r_done | (rem ^ rest));
            end else if (o_match.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_slot   <= SLOT_W'(sel);
            r_out_offset <= start_ofs;
            r_out_last   <= (rest == '0);
        end
    end

    assign o_match.valid        = r_out_vld;
    assign o_match.match_slot   = r_out_slot;
    assign o_match.match_offset = r_out_offset;
    assign o_match.last_match   = r_out_last;

endmodule

@@ rtl/multi_keyword_byte_matcher.sv @@
// -----------------------------------------------------------------------------
// Multi-keyword byte matcher
// Finds up to sixteen exact keywords of up to 32 bytes in a scanned byte
// stream and reports each one as its last byte arrives.
// -----------------------------------------------------------------------------
// The block takes one item per clock unless the input is held off. Keyword
// byte writes, scan bytes and restarts never stall the input unless the hit
// queue is full. A keyword length write starts a realignment of that slot
// that reads its 32 stored bytes back through the single read port of the
// keyword RAM, so the input is held off until the slot is realigned. Every
// scan byte is compared against all slots in parallel in the cycle after
// its transfer; bytes with no hit leave no trace on the output. A byte
// that hits k slots produces k result transfers in ascending slot order,
// one per cycle while the receiver is ready; the last one of the byte
// carries last_match. A four-entry queue between the compare stage and
// the result sequencer absorbs bursts of hits and output stalls; the
// output register holds a result until it is taken. A restart clears the
// history and resets the stream offset to zero but keeps the keyword
// table. The offset saturates at its all-ones value.
// -----------------------------------------------------------------------------
`include "multi_keyword_byte_matcher_macros.svh"

module multi_keyword_byte_matcher
    import mkbm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mkbm_item_if.sink    i_item,
    mkbm_match_if.source o_match
);

    // Front to queue: one record per scanned byte that hit any slot.
    logic      q_push;
    t_scan_res q_push_data;
    // Queue to back: head record and occupancy flags.
    t_scan_res q_head;
    t_q_status q_status;
    logic      q_pop;
    // High while a slot is being realigned after a length write.
    logic      sweep_busy;

    // The front end owns the keyword table, the history window and the
    // stream offset, and turns each scanned byte into a hit mask.
    mkbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_q_status   (q_status),
        .o_push       (q_push),
        .o_push_data  (q_push_data),
        .o_sweep_busy (sweep_busy)
    );

    mkbm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    // The back end drains one hit slot per cycle, when the output is not stalled,
    // into the output register and retires the head record with the last of them.
    mkbm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_match    (o_match)
    );

    // The front end must never push into a full queue, nor the back end
    // pop an empty one.
    `MKBM_ASSERT_IMP(a_no_overflow, q_push, !q_status.full)
    `MKBM_ASSERT_IMP(a_no_underflow, q_pop, !q_status.empty)
    // Retiring a record goes together with loading its last result.
    `MKBM_ASSERT_NXT(a_pop_with_last, q_pop, o_match.valid && o_match.last_match)
    // No item may be taken while a slot realignment is in progress.
    `MKBM_ASSERT_IMP(a_hold_in_sweep, sweep_busy, !i_item.ready)

endmodule

@@ bench/mkbm_checker.sv @@
// -----------------------------------------------------------------------------
// Multi-keyword byte matcher result checker
// Watches both channels, keeps its own copy of the keyword table and the
// scan history, and compares every match transfer with the oldest match
// that it has worked out from the accepted items.
// -----------------------------------------------------------------------------
module mkbm_checker
    import mkbm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mkbm_item_if  i_item,
    mkbm_match_if i_match,
    output int    o_fail_count,
    output int    o_awaited,
    output int    o_matches_seen
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [OFS_W-1:0]  offset;
        logic              last;
    } t_match_rec;

    localparam int PRINT_LIMIT = 30;

    logic [BYTE_W-1:0] kw_bytes [NUM_KEYWORDS][MAX_LEN];
    logic [LEN_W-1:0]  kw_len   [NUM_KEYWORDS];
    logic [BYTE_W-1:0] history  [MAX_LEN];
    int                history_fill;
    logic [OFS_W-1:0]  next_offset;
    t_match_rec        awaited_matches [$];
    int                mismatches   = 0;
    int                matches_seen = 0;

    task automatic clear_model();
        int s;
        int p;
        for (s = 0; s < NUM_KEYWORDS; s++) begin
            kw_len[s] = '0;
            for (p = 0; p < MAX_LEN; p++) kw_bytes[s][p] = '0;
        end
        for (p = 0; p < MAX_LEN; p++) history[p] = '0;
        history_fill = 0;
        next_offset  = '0;
        awaited_matches.delete();
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // True when the whole keyword of slot s ends at the newest history byte.
    function automatic bit keyword_ends_here(input int s);
        int n;
        int i;
        n = kw_len[s];
        if (n == 0 || n > MAX_LEN || history_fill < n) return 1'b0;
        for (i = 0; i < n; i++) begin
            if (kw_bytes[s][n-1-i] !== history[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic absorb_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                               input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] value,
                               input logic [LEN_W-1:0] plen);
        logic [OFS_W-1:0]        here;
        logic [NUM_KEYWORDS-1:0] hit_mask;
        t_match_rec              rec;
        int                      i;
        case (mode)
            MODE_KEY_BYTE: begin
                if (slot < NUM_KEYWORDS && pos < MAX_LEN) kw_bytes[slot][pos] = value;
            end
            MODE_KEY_LEN: begin
                if (slot < NUM_KEYWORDS) kw_len[slot] = (plen > MAX_LEN) ? LEN_W'(MAX_LEN) : plen;
            end
            MODE_RESTART: begin
                for (i = 0; i < MAX_LEN; i++) history[i] = '0;
                history_fill = 0;
                next_offset  = '0;
            end
            MODE_SCAN: begin
                for (i = MAX_LEN - 1; i > 0; i--) history[i] = history[i-1];
                history[0] = value;
                if (history_fill < MAX_LEN) history_fill++;
                here = next_offset;
                if (next_offset != OFFSET_MAX) next_offset++;
                for (i = 0; i < NUM_KEYWORDS; i++) hit_mask[i] = keyword_ends_here(i);
                for (i = 0; i < NUM_KEYWORDS; i++) begin
                    if (hit_mask[i]) begin
                        rec.slot   = SLOT_W'(i);
                        rec.offset = here - OFS_W'(kw_len[i]) + OFS_W'(1);
                        rec.last   = ((hit_mask >> (i + 1)) == '0);
                        awaited_matches.push_back(rec);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_match();
        t_match_rec want;
        matches_seen++;
        if (awaited_matches.size() == 0) begin
            report_mismatch($sformatf("match slot %0d offset %0d last %0b with none awaited",
                                      i_match.match_slot, i_match.match_offset,
                                      i_match.last_match));
        end else begin
            want = awaited_matches.pop_front();
            if (i_match.match_slot !== want.slot)
                report_mismatch($sformatf("match_slot %0d, expected %0d (offset %0d)",
                                          i_match.match_slot, want.slot, want.offset));
            if (i_match.match_offset !== want.offset)
                report_mismatch($sformatf("match_offset %0d, expected %0d (slot %0d)",
                                          i_match.match_offset, want.offset, want.slot));
            if (i_match.last_match !== want.last)
                report_mismatch($sformatf("last_match %0b, expected %0b (slot %0d offset %0d)",
                                          i_match.last_match, want.last, want.slot,
                                          want.offset));
        end
    endtask

    // Results are checked before the item of the same edge is absorbed; a scan
    // byte cannot produce its first match in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_match.valid === 1'b1 && i_match.ready === 1'b1) check_match();
            if (i_item.valid === 1'b1 && i_item.ready === 1'b1)
                absorb_item(i_item.mode, i_item.slot, i_item.char_pos, i_item.byte_value,
                            i_item.pattern_length);
        end
        o_fail_count   <= mismatches;
        o_awaited      <= awaited_matches.size();
        o_matches_seen <= matches_seen;
    end

endmodule

@@ bench/tb_top.sv @@
// -----------------------------------------------------------------------------
// Multi-keyword byte matcher testbench
// Drives keyword loads, scan bytes and restarts into the matcher with random
// gaps and output stalls, and lets the checker compare every match transfer.
// -----------------------------------------------------------------------------
module tb_top;
    import mkbm_pkg::*;

    localparam int ITEM_TARGET    = 330;
    localparam int PRESSURE_AT    = 140;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RESET_CYCLES   = 7;

    logic i_clk    = 1'b0;
    logic i_rst_n;
    logic hold_req = 1'b0;

    int fail_count;
    int awaited;
    int matches_seen;
    int idle_cycles = 0;

    // Stimulus bookkeeping. The keyword copies here only steer the stream
    // toward real hits; the checker keeps its own table for prediction.
    bit                no_gaps       = 1'b0;
    bit                pressure_done = 1'b0;
    int                item_count    = 0;
    int                scan_count    = 0;
    int                load_count    = 0;
    int                restart_count = 0;
    logic [BYTE_W-1:0] key_text   [NUM_KEYWORDS][MAX_LEN];
    logic [MAX_LEN-1:0] key_filled [NUM_KEYWORDS];
    int                key_len    [NUM_KEYWORDS];

    mkbm_item_if  item_ch ();
    mkbm_match_if match_ch ();

    multi_keyword_byte_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_match (match_ch)
    );

    mkbm_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_match        (match_ch),
        .o_fail_count   (fail_count),
        .o_awaited      (awaited),
        .o_matches_seen (matches_seen)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a run that makes no transfer on either channel for this long
    // has hung. The input stall after each length write and the output
    // hold-off are both well inside the limit.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (match_ch.valid && match_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Pause length shared by both sides: mostly none or short, a few long.
    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Half the bytes come from a two-letter alphabet so that keywords overlap
    // and repeat; the rest span the whole byte range.
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 1) == 0) return BYTE_W'(8'h41 + $urandom_range(0, 1));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Longest length that may be written to a slot without covering a keyword
    // byte that was never written. A fully written slot may take any length,
    // including those above MAX_LEN that the block saturates.
    function automatic int len_limit(input int s);
        int p;
        p = 0;
        while (p < MAX_LEN && key_filled[s][p]) p++;
        if (p == MAX_LEN) return (1 << LEN_W) - 1;
        return p;
    endfunction

    // One transfer on the item channel. Valid stays high from one transfer to
    // the next unless a gap is drawn, so back-to-back items are exercised.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                             input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] value,
                             input logic [LEN_W-1:0] plen);
        int gap;
        gap = no_gaps ? 0 : draw_pause();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.mode           <= mode;
        item_ch.slot           <= slot;
        item_ch.char_pos       <= pos;
        item_ch.byte_value     <= value;
        item_ch.pattern_length <= plen;
        @(posedge i_clk);
        while (item_ch.ready !== 1'b1) @(posedge i_clk);
        item_count++;
    endtask

    // Fields that a mode does not use carry random values.
    task automatic key_byte(input int s, input int p, input logic [BYTE_W-1:0] value);
        send_item(MODE_KEY_BYTE, SLOT_W'(s), POS_W'(p), value, LEN_W'($urandom_range(0, 63)));
        key_text[s][p]   = value;
        key_filled[s][p] = 1'b1;
        load_count++;
    endtask

    task automatic key_len_write(input int s, input int plen);
        send_item(MODE_KEY_LEN, SLOT_W'(s), POS_W'($urandom_range(0, 31)),
                  BYTE_W'($urandom_range(0, 255)), LEN_W'(plen));
        key_len[s] = (plen > MAX_LEN) ? MAX_LEN : plen;
        load_count++;
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] value);
        send_item(MODE_SCAN, SLOT_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 31)),
                  value, LEN_W'($urandom_range(0, 63)));
        scan_count++;
    endtask

    task automatic restart_image();
        send_item(MODE_RESTART, SLOT_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 31)),
                  BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 63)));
        restart_count++;
    endtask

    // Writes a fresh keyword into a random slot in ascending or descending byte order,
    // then sets its length: usually the keyword's own, sometimes another within the
    // written part, zero to disable, or oversized when the slot is fully written.
    task automatic load_keyword();
        int s;
        int n;
        int p;
        int r;
        int lim;
        int plen;
        bit narrow;
        bit upward;
        s      = $urandom_range(0, NUM_KEYWORDS - 1);
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_LEN) : $urandom_range(1, 6);
        narrow = $urandom_range(0, 1);
        upward = $urandom_range(0, 1);
        for (p = 0; p < n; p++) begin
            key_byte(s, upward ? p : n - 1 - p,
                     narrow ? BYTE_W'(8'h41 + $urandom_range(0, 1))
                            : BYTE_W'($urandom_range(0, 255)));
        end
        lim = len_limit(s);
        r   = $urandom_range(0, 99);
        if (r < 8) plen = 0;
        else if (r < 20) plen = $urandom_range(1, lim);
        else if (lim > MAX_LEN && r < 35) plen = $urandom_range(MAX_LEN + 1, lim);
        else plen = n;
        key_len_write(s, plen);
    endtask

    // A run of scan bytes in which enabled keywords are planted whole among
    // random bytes, so hits, near misses and overlapping hits all occur.
    task automatic scan_stream();
        int n;
        int sent;
        int s;
        int p;
        int live[$];
        n    = $urandom_range(4, 20);
        sent = 0;
        for (s = 0; s < NUM_KEYWORDS; s++) begin
            if (key_len[s] > 0) live.push_back(s);
        end
        while (sent < n) begin
            if (live.size() > 0 && $urandom_range(0, 99) < 40) begin
                s = live[$urandom_range(0, live.size() - 1)];
                for (p = 0; p < key_len[s]; p++) scan_byte(key_text[s][p]);
                sent += key_len[s];
            end else begin
                scan_byte(pick_byte());
                sent++;
            end
        end
    endtask

    // Single items with random fields; length writes still never reach past
    // the written part of a slot.
    task automatic noise_item();
        int s;
        case (MODE_W'($urandom_range(0, 3)))
            MODE_KEY_BYTE: key_byte($urandom_range(0, NUM_KEYWORDS - 1), $urandom_range(0, 31),
                                    BYTE_W'($urandom_range(0, 255)));
            MODE_KEY_LEN: begin
                s = $urandom_range(0, NUM_KEYWORDS - 1);
                key_len_write(s, $urandom_range(0, len_limit(s)));
            end
            MODE_SCAN: scan_byte(BYTE_W'($urandom_range(0, 255)));
            default: restart_image();
        endcase
    endtask

    // A keyword of the full width with an oversized length, which the block
    // saturates to MAX_LEN, followed by a random byte and then an occurrence of it.
    task automatic long_keyword();
        int s;
        int p;
        s = $urandom_range(0, NUM_KEYWORDS - 1);
        for (p = 0; p < MAX_LEN; p++) key_byte(s, p, pick_byte());
        key_len_write(s, $urandom_range(MAX_LEN + 1, (1 << LEN_W) - 1));
        scan_byte(pick_byte());
        for (p = 0; p < MAX_LEN; p++) scan_byte(key_text[s][p]);
    endtask

    // Every slot gets the same one-byte keyword, so each scan of that byte
    // hits all sixteen slots. The receiver holds off meanwhile, the hit queue
    // fills and the block has to stall its input.
    task automatic pressure_phase();
        int s;
        for (s = 0; s < NUM_KEYWORDS; s++) begin
            key_byte(s, 0, BYTE_W'(8'h5C));
            key_len_write(s, 1);
        end
        no_gaps  = 1'b1;
        hold_req <= 1'b1;
        repeat (12) scan_byte(BYTE_W'(8'h5C));
    endtask

    // Result side: ready runs and stalls of random length, now and then a
    // long stretch of steady ready, and one long hold-off on request.
    initial begin : result_acceptor
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        match_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                match_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req <= 1'b0;
            end else if (stall_left > 0) begin
                match_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                match_ch.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(0, 12);
                    stall_left = draw_pause();
                end
            end
        end
    end

    initial begin : stimulus
        int s;
        int r;
        i_rst_n                <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.mode           <= MODE_SCAN;
        item_ch.slot           <= '0;
        item_ch.char_pos       <= '0;
        item_ch.byte_value     <= '0;
        item_ch.pattern_length <= '0;
        for (s = 0; s < NUM_KEYWORDS; s++) begin
            key_filled[s] = '0;
            key_len[s]    = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A scan with every slot disabled gives nothing.
        scan_byte(BYTE_W'(8'h00));
        // Byte extremes, and three slots whose keywords end on the same byte.
        key_byte(0, 0, BYTE_W'(8'h00));
        key_byte(0, 1, BYTE_W'(8'hFF));
        key_len_write(0, 2);
        key_byte(15, 0, BYTE_W'(8'hFF));
        key_len_write(15, 1);
        key_byte(9, 0, BYTE_W'(8'hFF));
        key_byte(9, 1, BYTE_W'(8'hFF));
        key_len_write(9, 2);
        // Several hits per byte, and a keyword that overlaps itself.
        scan_byte(BYTE_W'(8'h00));
        scan_byte(BYTE_W'(8'hFF));
        scan_byte(BYTE_W'(8'hFF));
        scan_byte(BYTE_W'(8'hFF));
        // A restart clears the history: no two-byte hit across it, offset at 0.
        restart_image();
        scan_byte(BYTE_W'(8'hFF));
        // A zero length disables a slot.
        key_len_write(15, 0);
        scan_byte(BYTE_W'(8'hFF));
        // Highest position in the highest slot, then a shortened keyword.
        key_byte(15, MAX_LEN - 1, BYTE_W'(8'h55));
        key_len_write(0, 1);
        scan_byte(BYTE_W'(8'h00));

        long_keyword();

        // Random part, with one pressure phase partway through.
        while (item_count < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (!pressure_done && item_count >= PRESSURE_AT) begin
                pressure_phase();
                pressure_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) load_keyword();
                else if (r < 75) scan_stream();
                else if (r < 83) restart_image();
                else noise_item();
            end
        end
        item_ch.valid <= 1'b0;

        // Wait for every predicted match, then give the pipeline time to show
        // any transfer that should not come.
        @(negedge i_clk);
        while (awaited != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run drove %0d item transfers: %0d keyword loads, %0d scan bytes, %0d restarts.",
                 item_count, load_count, scan_count, restart_count);
        $display("Checked %0d match transfers, including a %0d-cycle output hold-off.",
                 matches_seen, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mkbm_pkg.sv
rtl/mkbm_if.sv
rtl/mkbm_ram.sv
rtl/mkbm_front.sv
rtl/mkbm_queue.sv
rtl/mkbm_back.sv
rtl/multi_keyword_byte_matcher.sv
bench/mkbm_checker.sv
bench/tb_top.sv
